### hdl/cmdp_pkg.sv
// Shared types and constants for the text motor command parser.
// Result codes, ASCII codes and the result bundle. No dependencies.
`timescale 1ns / 1ps

package cmdp_pkg;

   localparam logic [2:0] KIND_INVALID   = 3'd0;
   localparam logic [2:0] KIND_MOTORS    = 3'd1;
   localparam logic [2:0] KIND_JOYSTICK  = 3'd2;
   localparam logic [2:0] KIND_STOP      = 3'd3;
   localparam logic [2:0] KIND_KEEPALIVE = 3'd4;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_C     = 8'h43;
   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_J     = 8'h4A;
   localparam logic [7:0] CH_M     = 8'h4D;
   localparam logic [7:0] CH_O     = 8'h4F;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_S     = 8'h53;
   localparam logic [7:0] CH_T     = 8'h54;

   typedef struct packed {
      logic [2:0]         kind;
      logic [15:0]        seq_number;
      logic signed [15:0] left_speed;
      logic signed [15:0] right_speed;
      logic signed [15:0] actuator;
      logic signed [15:0] brush;
      logic signed [15:0] lamp;
      logic signed [15:0] joy_x;
      logic signed [15:0] joy_y;
   } cmdp_result_type;

   function automatic logic [7:0] cmd_char(input logic [1:0] idx);
      case (idx)
         2'd0:    cmd_char = CH_C;
         2'd1:    cmd_char = CH_M;
         default: cmd_char = CH_D;
      endcase
   endfunction

   function automatic logic [7:0] stop_char(input logic [1:0] idx);
      case (idx)
         2'd0:    stop_char = CH_S;
         2'd1:    stop_char = CH_T;
         2'd2:    stop_char = CH_O;
         default: stop_char = CH_P;
      endcase
   endfunction

endpackage

### hdl/cmdp_parser.sv
// Per-character line grammar state machine with decimal accumulate.
// Builds the result bundle on the end-of-line character. Uses cmdp_pkg.
`timescale 1ns / 1ps

module cmdp_parser
   import cmdp_pkg::*;
#(
   parameter int VALUE_WIDTH = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            take,
   input  logic [7:0]      ch,
   input  logic            end_of_line,
   output cmdp_result_type result
);

   localparam int VW = VALUE_WIDTH;

   typedef enum logic [3:0] {
      PH_LIT, PH_SEQ_WS, PH_SEQ_SGN, PH_SEQ_DIG, PH_KEY_WS,
      PH_VAL_WS, PH_VAL_SGN, PH_VAL_DIG, PH_STOP, PH_DONE
   } phase_type;

   typedef enum logic [1:0] {LET_NONE, LET_M, LET_J, LET_S} letter_type;

   phase_type        phase_ff, phase_f, phase_in;
   logic [2:0]       lit_ff, lit_f, lit_in;
   logic [VW-1:0]    seq_ff, seq_f, seq_in;
   logic             seq_ok_ff, seq_ok_f, seq_ok_in;
   logic [VW-1:0]    acc_ff, acc_f, acc_in;
   logic             minus_ff, minus_f, minus_in;
   letter_type       letter_ff, letter_f, letter_in;
   logic [2:0]       filled_ff, filled_f, filled_in;
   logic [VW-1:0]    vals_ff [5];
   logic [VW-1:0]    vals_f [5];
   logic [VW-1:0]    vals_in [5];

   logic             is_ws, is_dig, redo;
   logic [3:0]       dig;
   logic [VW-1:0]    fin_a, fin_e, seq_e;
   logic             seq_ok_e;
   logic [2:0]       filled_e, limit;
   logic [VW-1:0]    vals_e [5];

   assign is_ws  = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
   assign is_dig = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign dig    = 4'(ch - CH_ZERO);
   assign fin_a  = minus_ff ? (VW'(0) - acc_ff) : acc_ff;
   assign limit  = (letter_ff == LET_M) ? 3'd5 : 3'd2;

   // one character step; a non-digit that ends a number is dispatched again
   always_comb begin
      phase_f  = phase_ff;
      lit_f    = lit_ff;
      seq_f    = seq_ff;
      seq_ok_f = seq_ok_ff;
      acc_f    = acc_ff;
      minus_f  = minus_ff;
      letter_f = letter_ff;
      filled_f = filled_ff;
      vals_f   = vals_ff;
      redo     = 1'b1;
      if (phase_ff == PH_SEQ_DIG || phase_ff == PH_VAL_DIG) begin
         if (is_dig) begin
            acc_f = (acc_ff << 3) + (acc_ff << 1) + VW'(dig);
            redo  = 1'b0;
         end else if (phase_ff == PH_SEQ_DIG) begin
            seq_f    = fin_a;
            seq_ok_f = 1'b1;
            phase_f  = PH_KEY_WS;
         end else begin
            for (int i = 0; i < 5; i++) begin
               if (filled_ff == 3'(i)) begin
                  vals_f[i] = fin_a;
               end
            end
            filled_f = filled_ff + 3'd1;
            phase_f  = (filled_f >= limit) ? PH_DONE : PH_VAL_WS;
         end
      end
      if (redo) begin
         case (phase_f)
            PH_LIT: begin
               if (lit_f < 3'd3 && ch == cmd_char(lit_f[1:0])) begin
                  lit_f = lit_f + 3'd1;
                  if (lit_f == 3'd3) begin
                     phase_f = PH_SEQ_WS;
                  end
               end else begin
                  phase_f = PH_DONE;
               end
            end
            PH_SEQ_WS, PH_VAL_WS: begin
               if (!is_ws) begin
                  acc_f   = '0;
                  minus_f = (ch == CH_MINUS);
                  if (ch == CH_PLUS || ch == CH_MINUS) begin
                     phase_f = (phase_f == PH_SEQ_WS) ? PH_SEQ_SGN : PH_VAL_SGN;
                  end else if (is_dig) begin
                     acc_f   = VW'(dig);
                     phase_f = (phase_f == PH_SEQ_WS) ? PH_SEQ_DIG : PH_VAL_DIG;
                  end else begin
                     phase_f = PH_DONE;
                  end
               end
            end
            PH_SEQ_SGN, PH_VAL_SGN: begin
               if (is_dig) begin
                  acc_f   = VW'(dig);
                  phase_f = (phase_f == PH_SEQ_SGN) ? PH_SEQ_DIG : PH_VAL_DIG;
               end else begin
                  phase_f = PH_DONE;
               end
            end
            PH_KEY_WS: begin
               if (!is_ws) begin
                  if (ch == CH_M) begin
                     letter_f = LET_M;
                     phase_f  = PH_VAL_WS;
                  end else if (ch == CH_J) begin
                     letter_f = LET_J;
                     phase_f  = PH_VAL_WS;
                  end else if (ch == CH_S) begin
                     letter_f = LET_S;
                     lit_f    = 3'd1;
                     phase_f  = PH_STOP;
                  end else begin
                     phase_f = PH_DONE;
                  end
               end
            end
            PH_STOP: begin
               if (lit_f < 3'd4 && ch == stop_char(lit_f[1:0])) begin
                  lit_f = lit_f + 3'd1;
                  if (lit_f == 3'd4) begin
                     phase_f = PH_DONE;
                  end
               end else begin
                  phase_f = PH_DONE;
               end
            end
            default: begin
               phase_f = PH_DONE;
            end
         endcase
      end
   end

   // a number still open at end of line counts as complete
   assign fin_e    = minus_f ? (VW'(0) - acc_f) : acc_f;
   assign seq_e    = (phase_f == PH_SEQ_DIG) ? fin_e : seq_f;
   assign seq_ok_e = seq_ok_f || (phase_f == PH_SEQ_DIG);
   assign filled_e = filled_f + ((phase_f == PH_VAL_DIG) ? 3'd1 : 3'd0);

   always_comb begin
      for (int i = 0; i < 5; i++) begin
         vals_e[i] = (phase_f == PH_VAL_DIG && filled_f == 3'(i)) ? fin_e : vals_f[i];
      end
   end

   always_comb begin
      result = '0;
      if (seq_ok_e) begin
         if (letter_f == LET_M && filled_e >= 3'd2) begin
            result.kind = KIND_MOTORS;
         end else if (letter_f == LET_J && filled_e >= 3'd2) begin
            result.kind = KIND_JOYSTICK;
         end else if (letter_f == LET_S && lit_f == 3'd4) begin
            result.kind = KIND_STOP;
         end else begin
            result.kind = KIND_KEEPALIVE;
         end
         result.seq_number = 16'(seq_e);
      end
      if (result.kind == KIND_MOTORS) begin
         result.left_speed  = 16'($signed(vals_e[0]));
         result.right_speed = 16'($signed(vals_e[1]));
         result.actuator    = 16'($signed(vals_e[2]));
         result.brush       = 16'($signed(vals_e[3]));
         result.lamp        = 16'($signed(vals_e[4]));
      end else if (result.kind == KIND_JOYSTICK) begin
         result.joy_x = 16'($signed(vals_e[0]));
         result.joy_y = 16'($signed(vals_e[1]));
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      lit_in    = lit_ff;
      seq_in    = seq_ff;
      seq_ok_in = seq_ok_ff;
      acc_in    = acc_ff;
      minus_in  = minus_ff;
      letter_in = letter_ff;
      filled_in = filled_ff;
      vals_in   = vals_ff;
      if (take) begin
         if (end_of_line) begin
            phase_in  = PH_LIT;
            lit_in    = '0;
            seq_in    = '0;
            seq_ok_in = 1'b0;
            acc_in    = '0;
            minus_in  = 1'b0;
            letter_in = LET_NONE;
            filled_in = '0;
            for (int i = 0; i < 5; i++) begin
               vals_in[i] = '0;
            end
         end else begin
            phase_in  = phase_f;
            lit_in    = lit_f;
            seq_in    = seq_f;
            seq_ok_in = seq_ok_f;
            acc_in    = acc_f;
            minus_in  = minus_f;
            letter_in = letter_f;
            filled_in = filled_f;
            vals_in   = vals_f;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_LIT;
         lit_ff    <= '0;
         seq_ff    <= '0;
         seq_ok_ff <= 1'b0;
         acc_ff    <= '0;
         minus_ff  <= 1'b0;
         letter_ff <= LET_NONE;
         filled_ff <= '0;
         for (int i = 0; i < 5; i++) begin
            vals_ff[i] <= '0;
         end
      end else begin
         phase_ff  <= phase_in;
         lit_ff    <= lit_in;
         seq_ff    <= seq_in;
         seq_ok_ff <= seq_ok_in;
         acc_ff    <= acc_in;
         minus_ff  <= minus_in;
         letter_ff <= letter_in;
         filled_ff <= filled_in;
         vals_ff   <= vals_in;
      end
   end

endmodule

### hdl/cmdp_out_reg.sv
// Result register for the command parser's response channel.
// Holds one decoded command until taken. Uses cmdp_pkg.
`timescale 1ns / 1ps

module cmdp_out_reg
   import cmdp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  cmdp_result_type load_data,
   input  logic            rsp_ready,
   output logic            rsp_valid,
   output cmdp_result_type rsp_data,
   output logic            free
);

   logic            valid_ff, valid_in;
   cmdp_result_type data_ff, data_in;

   assign free      = !valid_ff || rsp_ready;
   assign valid_in  = load || (valid_ff && !rsp_ready);
   assign data_in   = load ? load_data : data_ff;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule

### hdl/text_motor_command_parser.sv
// Text motor command parser top level: parser state machine and result register.
// Depends on cmdp_pkg, cmdp_parser and cmdp_out_reg.
`timescale 1ns / 1ps

// Takes one character per cycle and emits one decoded command per line. A
// character is accepted whenever the result register is empty or its result is
// being taken in the same cycle, so a steady stream runs at one character per
// clock. The result of a line appears on the rsp_ channel in the cycle after its
// end_of_line character is accepted. The rate is set by the combinational
// character step of the grammar state machine, which includes the
// multiply-by-ten accumulate of VALUE_WIDTH bits.

module text_motor_command_parser
   import cmdp_pkg::*;
#(
   parameter int VALUE_WIDTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_ch,
   input  logic               req_end_of_line,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_kind,
   output logic [15:0]        rsp_seq_number,
   output logic signed [15:0] rsp_left_speed,
   output logic signed [15:0] rsp_right_speed,
   output logic signed [15:0] rsp_actuator,
   output logic signed [15:0] rsp_brush,
   output logic signed [15:0] rsp_lamp,
   output logic signed [15:0] rsp_joy_x,
   output logic signed [15:0] rsp_joy_y
);

   logic            take, free;
   cmdp_result_type line_result, rsp_data;

   assign req_ready = free;
   assign take      = req_valid && free;

   cmdp_parser #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .ch         (req_ch),
      .end_of_line(req_end_of_line),
      .result     (line_result)
   );

   cmdp_out_reg u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (take && req_end_of_line),
      .load_data(line_result),
      .rsp_ready(rsp_ready),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .free     (free)
   );

   assign rsp_kind        = rsp_data.kind;
   assign rsp_seq_number  = rsp_data.seq_number;
   assign rsp_left_speed  = rsp_data.left_speed;
   assign rsp_right_speed = rsp_data.right_speed;
   assign rsp_actuator    = rsp_data.actuator;
   assign rsp_brush       = rsp_data.brush;
   assign rsp_lamp        = rsp_data.lamp;
   assign rsp_joy_x       = rsp_data.joy_x;
   assign rsp_joy_y       = rsp_data.joy_y;

endmodule

### hdl/cmdp_checker.sv
// Port-level checks for the text motor command parser, bound to the top level.
// Depends on cmdp_pkg and text_motor_command_parser.
`timescale 1ns / 1ps

module cmdp_checker
   import cmdp_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [7:0]         req_ch,
   input logic               req_end_of_line,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [2:0]         rsp_kind,
   input logic [15:0]        rsp_seq_number,
   input logic signed [15:0] rsp_left_speed,
   input logic signed [15:0] rsp_right_speed,
   input logic signed [15:0] rsp_actuator,
   input logic signed [15:0] rsp_brush,
   input logic signed [15:0] rsp_lamp,
   input logic signed [15:0] rsp_joy_x,
   input logic signed [15:0] rsp_joy_y
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_seq_number) && $stable(rsp_left_speed) && $stable(rsp_joy_x))
      else $error("stalled response transaction changed");

   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && req_valid && req_ready && !req_end_of_line |=> !rsp_valid)
      else $error("response without end of line");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_INVALID |-> rsp_seq_number == 16'd0
         && rsp_left_speed == 16'sd0 && rsp_joy_x == 16'sd0 && rsp_joy_y == 16'sd0)
      else $error("invalid line with nonzero fields");

   a_motor_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_MOTORS |-> rsp_left_speed == 16'sd0
         && rsp_right_speed == 16'sd0 && rsp_actuator == 16'sd0
         && rsp_brush == 16'sd0 && rsp_lamp == 16'sd0)
      else $error("motor fields set on other kind");

   a_joy_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_JOYSTICK |-> rsp_joy_x == 16'sd0 && rsp_joy_y == 16'sd0)
      else $error("joystick fields set on other kind");

endmodule

bind text_motor_command_parser cmdp_checker u_cmdp_checker (.*);
